>>> src/lfu_pkg.sv
// Shared types and constants for the LFU key/value store.
package lfu_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  localparam logic [1:0] REG_CAPACITY = 2'd0;

  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } lfu_req_t;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
  } lfu_rsp_t;

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVICT,
    ST_ADJ,
    ST_WRITE,
    ST_RESP
  } lfu_state_t;

endpackage

>>> src/lfu_cache_store.sv
// Top level of the LFU key/value store with LRU tie-break.
//
// Channel  Direction  Handshake           Payload
// req      in         req_valid/req_ready lfu_req_t (kind, key, value)
// rsp      out        rsp_valid/rsp_ready lfu_rsp_t (hit, read_value)
// cfg      in         APB psel/penable    capacity_in_use at address 0
//
// A get miss or a put at zero capacity answers straight after the key scan; any
// other request also passes the rank adjustment and the write, and each eviction
// adds an eviction step, a rank adjustment and a new scan. The time is set by the
// scan of the entry memory through its single read port, one entry a cycle,
// first to find the key and the victim, then to adjust the recency ranks.
// Reset clears the valid bits and the occupancy; no clearing pass is needed.
// A response waits in its output register while rsp_ready is low; the next
// request is taken only after the response has been taken and the FSM is idle.
module lfu_cache_store
  import lfu_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  lfu_req_t    req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output lfu_rsp_t    rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int RANK_W = IDX_W;
  localparam int ENT_W = KEY_W + VAL_W + COUNT_BITS + RANK_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [VAL_W-1:0]      value;
    logic [COUNT_BITS-1:0] count;
    logic [RANK_W-1:0]     rank;
  } entry_t;

  // Entry memory, one read and one write port.
  logic [ENT_W-1:0] mem [CAPACITY];
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;
  entry_t           mem_wdata;
  entry_t           rd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd <= mem[mem_raddr];
  end

  logic [CAPACITY-1:0] valid;
  logic [CNT_W-1:0]    occ;
  logic [CAP_W-1:0]    cap_reg;

  lfu_state_t state, state_next;
  lfu_req_t   cur;
  logic [IDX_W:0]   ctr;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_live;
  logic             found;
  logic [IDX_W-1:0] hit_idx;
  entry_t           hit_ent;
  logic             vic_ok;
  logic [IDX_W-1:0] vic_idx;
  entry_t           vic_ent;
  logic             evicting;
  logic [RANK_W-1:0] ref_rank;
  lfu_rsp_t         rsp_reg;
  logic             rsp_v;

  logic [CNT_W-1:0] cap_eff;
  assign cap_eff = (32'(cap_reg) > CAPACITY) ? CNT_W'(CAPACITY) : CNT_W'(cap_reg);

  logic last_scan;
  assign last_scan = (ctr == (IDX_W+1)'(CAPACITY));

  // The scan ends once the last entry read has been compared.
  logic scan_end;
  assign scan_end = last_scan && !rd_live;

  // Free slot: lowest entry without a valid bit.
  logic [IDX_W-1:0] free_idx;
  always_comb begin
    free_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  logic need_evict;
  assign need_evict = (occ >= cap_eff) && (occ != '0);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (req_valid && req_ready) state_next = ST_SCAN;
      ST_SCAN: begin
        if (scan_end) begin
          if (found) begin
            state_next = (cur.kind == KIND_GET || cap_eff != '0) ? ST_ADJ : ST_RESP;
          end else if (cur.kind == KIND_PUT && cap_eff != '0) begin
            state_next = need_evict ? ST_EVICT : ST_ADJ;
          end else begin
            state_next = ST_RESP;
          end
        end
      end
      ST_EVICT: state_next = ST_ADJ;
      ST_ADJ:   if (last_scan) state_next = evicting ? ST_SCAN : ST_WRITE;
      ST_WRITE: state_next = ST_RESP;
      ST_RESP:  if (!rsp_v) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  assign req_ready = (state == ST_IDLE) && !rsp_v;
  assign mem_raddr = ctr[IDX_W-1:0];

  // Rank adjust for the entry just read in ST_ADJ.
  entry_t adj_ent;
  always_comb begin
    adj_ent = rd;
    if (evicting) begin
      if (rd.rank > ref_rank) adj_ent.rank = rd.rank - 1'b1;
    end else if (found) begin
      if (rd.rank < ref_rank) adj_ent.rank = rd.rank + 1'b1;
    end else begin
      adj_ent.rank = rd.rank + 1'b1;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_idx;
    mem_wdata = adj_ent;
    if (state == ST_ADJ && rd_live && valid[rd_idx] &&
        !(evicting && rd_idx == vic_idx) && !(found && !evicting && rd_idx == hit_idx)) begin
      mem_we = 1'b1;
    end else if (state == ST_WRITE) begin
      mem_we = 1'b1;
      if (found) begin
        mem_waddr       = hit_idx;
        mem_wdata       = hit_ent;
        mem_wdata.rank  = '0;
        mem_wdata.count = (hit_ent.count == CNT_MAX) ? hit_ent.count : hit_ent.count + 1'b1;
        if (cur.kind == KIND_PUT) mem_wdata.value = cur.value;
      end else begin
        mem_waddr       = free_idx;
        mem_wdata.key   = cur.key;
        mem_wdata.value = cur.value;
        mem_wdata.count = COUNT_BITS'(1);
        mem_wdata.rank  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      valid   <= '0;
      occ     <= '0;
      cap_reg <= CAP_W'(16);
      rsp_v   <= 1'b0;
      rd_live <= 1'b0;
      ctr     <= '0;
    end else begin
      state   <= state_next;
      rd_live <= 1'b0;
      if (psel && penable && pwrite && paddr[2] == REG_CAPACITY[0]) begin
        cap_reg <= pwdata[CAP_W-1:0];
      end
      if (rsp_v && rsp_ready) rsp_v <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          ctr <= '0;
          if (req_valid && req_ready) begin
            cur      <= req;
            found    <= 1'b0;
            vic_ok   <= 1'b0;
            evicting <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (!last_scan) begin
            ctr     <= ctr + 1'b1;
            rd_live <= 1'b1;
            rd_idx  <= ctr[IDX_W-1:0];
          end
          if (rd_live && valid[rd_idx]) begin
            if (rd.key == cur.key) begin
              found   <= 1'b1;
              hit_idx <= rd_idx;
              hit_ent <= rd;
            end
            if (!vic_ok || rd.count < vic_ent.count ||
                (rd.count == vic_ent.count && rd.rank > vic_ent.rank)) begin
              vic_ok  <= 1'b1;
              vic_idx <= rd_idx;
              vic_ent <= rd;
            end
          end
          if (scan_end) begin
            ctr <= '0;
            if (found) begin
              ref_rank <= hit_ent.rank;
              rsp_reg.hit        <= 1'b1;
              rsp_reg.read_value <= (cur.kind == KIND_GET) ? hit_ent.value : '0;
            end else if (!evicting) begin
              rsp_reg.hit        <= 1'b0;
              rsp_reg.read_value <= '0;
            end
            evicting <= 1'b0;
            if (!found && cur.kind == KIND_PUT && cap_eff != '0 && need_evict) begin
              evicting <= 1'b1;
            end
          end
        end
        ST_EVICT: begin
          ref_rank       <= vic_ent.rank;
          valid[vic_idx] <= 1'b0;
          occ            <= occ - 1'b1;
        end
        ST_ADJ: begin
          if (!last_scan) begin
            ctr     <= ctr + 1'b1;
            rd_live <= 1'b1;
            rd_idx  <= ctr[IDX_W-1:0];
          end else begin
            ctr    <= '0;
            vic_ok <= 1'b0;
          end
        end
        ST_WRITE: begin
          if (!found) begin
            valid[free_idx] <= 1'b1;
            occ             <= occ + 1'b1;
          end
          rsp_v <= 1'b1;
        end
        ST_RESP: begin
          if (found && cur.kind == KIND_PUT && cap_eff == '0 && !rsp_v) begin
            rsp_v <= 1'b0;
          end
        end
        default: ;
      endcase
      if (state == ST_SCAN && scan_end && state_next == ST_RESP) rsp_v <= 1'b1;
    end
  end

  assign rsp_valid = rsp_v;
  assign rsp       = rsp_reg;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_CAPACITY[0]) ? 32'(cap_reg) : 32'd0;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !rsp_valid)
    else $error("request accepted while a response was pending");
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");
  a_occ_matches: assert property (@(posedge clk) disable iff (rst)
    CNT_W'($countones(valid)) == occ)
    else $error("occupancy differs from valid bits");
`endif

endmodule

>>> sim/lfu_cache_store_test.sv
// Self-checking testbench for the LFU key/value store with LRU tie-break.
module lfu_cache_store_test;
  import lfu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 16;
  localparam int CNT_MAX = 65535;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  lfu_req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  lfu_rsp_t rsp;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  lfu_cache_store u_dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the store.
  logic slot_valid [SLOTS];
  logic [KEY_W-1:0] slot_key [SLOTS];
  logic [VAL_W-1:0] slot_val [SLOTS];
  int unsigned slot_uses [SLOTS];
  int unsigned slot_age [SLOTS];
  int unsigned occupancy;
  int unsigned capacity;

  lfu_rsp_t expected_rsps[$];
  int errors;
  int idle_cycles;
  int rsp_hold;
  logic [KEY_W-1:0] key_pool [8];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int find_slot(input logic [KEY_W-1:0] k);
    for (int i = 0; i < SLOTS; i++)
      if (slot_valid[i] && slot_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void promote(input int e);
    for (int i = 0; i < SLOTS; i++)
      if (slot_valid[i] && slot_age[i] < slot_age[e]) slot_age[i]++;
    slot_age[e] = 0;
    if (slot_uses[e] < CNT_MAX) slot_uses[e]++;
  endfunction

  function automatic void evict_victim();
    int v;
    v = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (!slot_valid[i]) continue;
      if (v < 0 || slot_uses[i] < slot_uses[v] ||
          (slot_uses[i] == slot_uses[v] && slot_age[i] > slot_age[v])) v = i;
    end
    if (v < 0) return;
    for (int i = 0; i < SLOTS; i++)
      if (slot_valid[i] && slot_age[i] > slot_age[v]) slot_age[i]--;
    slot_valid[v] = 1'b0;
    if (occupancy > 0) occupancy--;
  endfunction

  function automatic void insert_entry(input logic [KEY_W-1:0] k, input logic [VAL_W-1:0] v);
    int s;
    s = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_valid[i]) slot_age[i]++;
      else if (s < 0) s = i;
    end
    if (s < 0) return;
    slot_valid[s] = 1'b1;
    slot_key[s] = k;
    slot_val[s] = v;
    slot_uses[s] = 1;
    slot_age[s] = 0;
    occupancy++;
  endfunction

  function automatic lfu_rsp_t predict_lookup(input lfu_req_t r);
    lfu_rsp_t o;
    int e;
    int unsigned cap;
    e = find_slot(r.key);
    cap = (capacity > SLOTS) ? SLOTS : capacity;
    o.hit = (e >= 0);
    o.read_value = '0;
    if (r.kind == KIND_GET) begin
      if (e >= 0) begin
        o.read_value = slot_val[e];
        promote(e);
      end
    end else if (cap != 0) begin
      if (e >= 0) begin
        slot_val[e] = r.value;
        promote(e);
      end else begin
        while (occupancy >= cap && occupancy > 0) evict_victim();
        insert_entry(r.key, r.value);
      end
    end
    return o;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  task automatic send_request(input logic kind, input logic [KEY_W-1:0] k,
                              input logic [VAL_W-1:0] v);
    lfu_req_t r;
    int g;
    r.kind = kind;
    r.key = k;
    r.value = v;
    g = gap_len();
    repeat (g + 1) @(posedge clk);
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    expected_rsps.push_back(predict_lookup(r));
    req_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_capacity(input int unsigned c);
    wait_drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {REG_CAPACITY, 1'b0} << 1;
    pwdata <= c;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    capacity = c & 5'h1f;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      rsp_hold <= 0;
    end else if (rsp_hold > 0) begin
      rsp_ready <= 1'b0;
      rsp_hold <= rsp_hold - 1;
    end else if ($urandom_range(0, 40) == 0) begin
      rsp_ready <= 1'b0;
      rsp_hold <= $urandom_range(10, 40);
    end else begin
      rsp_ready <= ($urandom_range(0, 9) < 7);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsps.size() == 0) begin
        $display("unexpected response %h at %0t", rsp, $realtime);
        errors++;
      end else begin
        lfu_rsp_t want;
        want = expected_rsps.pop_front();
        if (rsp.hit !== want.hit) report("hit", 32'(rsp.hit), 32'(want.hit));
        if (rsp.read_value !== want.read_value)
          report("read_value", rsp.read_value, want.read_value);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("lfu_cache_store_test: done, errors");
      $finish;
    end
  end

  task automatic test_extremes();
    send_request(KIND_GET, 32'h0, 32'h0);
    send_request(KIND_PUT, 32'h0, 32'hffff_ffff);
    send_request(KIND_PUT, 32'hffff_ffff, 32'h0);
    send_request(KIND_GET, 32'h0, 32'h1234_5678);
    send_request(KIND_GET, 32'hffff_ffff, 32'hffff_ffff);
    send_request(KIND_PUT, 32'h0, 32'h5555_aaaa);
    send_request(KIND_GET, 32'h0, 32'h0);
    send_request(KIND_GET, 32'h1, 32'h0);
  endtask

  task automatic test_eviction_ties();
    write_capacity(2);
    send_request(KIND_PUT, 32'h10, 32'h1);
    send_request(KIND_PUT, 32'h20, 32'h2);
    send_request(KIND_PUT, 32'h30, 32'h3);
    send_request(KIND_GET, 32'h20, 32'h0);
    send_request(KIND_GET, 32'h30, 32'h0);
    send_request(KIND_PUT, 32'h40, 32'h4);
    send_request(KIND_GET, 32'h30, 32'h0);
    send_request(KIND_GET, 32'h40, 32'h0);
  endtask

  task automatic test_capacity_zero();
    write_capacity(0);
    send_request(KIND_PUT, 32'h40, 32'h99);
    send_request(KIND_PUT, 32'h77, 32'h99);
    send_request(KIND_GET, 32'h40, 32'h0);
    send_request(KIND_GET, 32'h77, 32'h0);
  endtask

  task automatic run_random(input int n);
    logic [KEY_W-1:0] k;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) k = $urandom();
      else k = key_pool[$urandom_range(0, 7)] ^ $urandom_range(0, 3);
      send_request(1'($urandom_range(0, 1)), k, $urandom());
    end
  endtask

  task automatic test_random_capacities();
    int unsigned caps [6];
    caps = '{16, 31, 3, 8, 17, 1};
    foreach (key_pool[i]) key_pool[i] = $urandom();
    foreach (caps[c]) begin
      write_capacity(caps[c]);
      run_random(200);
    end
    write_capacity(16);
    run_random(200);
    write_capacity(2);
    run_random(200);
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) slot_valid[i] = 1'b0;
    occupancy = 0;
    capacity = 16;
    errors = 0;
    idle_cycles = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_eviction_ties();
    test_capacity_zero();
    test_random_capacities();
    wait_drain();
    if (errors == 0) $display("lfu_cache_store_test: done, clean");
    else $display("lfu_cache_store_test: done, errors");
    $finish;
  end
endmodule

>>> sim.f
src/lfu_pkg.sv
src/lfu_cache_store.sv
sim/lfu_cache_store_test.sv
